// File: hw/rtl/space_to_tab_entab_defines.svh
// Assertion macros for the entab RTL; ste_queue is the only file that uses them.
// Expects a clock named clk and a synchronous reset named rst in the using module.
`ifndef SPACE_TO_TAB_ENTAB_DEFINES_SVH
`define SPACE_TO_TAB_ENTAB_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define STE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("entab assertion failed");

// Checked on every clock edge, reset included.
`define STE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("entab assertion failed");

`else

`define STE_ASSERT(lbl, prop)
`define STE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: hw/rtl/ste_pkg.sv
// Shared types and constants for the space-to-tab converter.
// No dependencies; the front end, queue, back end and top level import this package.
package ste_pkg;

  localparam int MAX_TAB     = 16;
  localparam int TAB_W       = 5;
  localparam int COL_W       = 4;
  localparam int PEND_W      = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  localparam logic [7:0]       CH_SPACE  = 8'h20;
  localparam logic [7:0]       CH_TAB    = 8'h09;
  localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(8);

  // One queued command: a run of spaces followed by one closing byte.
  typedef struct packed {
    logic [COL_W-1:0] spaces;
    logic [7:0]       ch;
    logic             last;
  } cmd_t;

endpackage

// File: hw/rtl/ste_in_if.sv
// Input character channel: valid/ready handshake with one text byte per word.
// Depends on nothing.
interface ste_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

// File: hw/rtl/ste_out_if.sv
// Output character channel: valid/ready handshake with one text byte per word.
// Depends on nothing.
interface ste_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

// File: hw/rtl/ste_front.sv
// Front end: tracks the block column and pending spaces, turns input words into
// queued commands; a held space queues none. Depends on ste_pkg and ste_in_if.
module ste_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ste_pkg::TAB_W-1:0] cfg_data,
  ste_in_if.sink                    in_stream,
  input  logic                      queue_full,
  output logic                      push,
  output ste_pkg::cmd_t             push_cmd
);
  import ste_pkg::*;

  logic [TAB_W-1:0]  tab_size;
  logic [COL_W-1:0]  block_column;
  logic [PEND_W-1:0] pending_spaces;
  logic [COL_W-1:0]  block_column_next;
  logic [PEND_W-1:0] pending_spaces_next;

  logic [TAB_W-1:0]  ts_eff;
  logic [TAB_W-1:0]  col_base;
  logic [TAB_W-1:0]  col;
  logic [PEND_W-1:0] pend_inc;
  logic              blk_end;
  logic              is_space;
  logic              accept;
  logic              emit;

  assign in_stream.ready = !queue_full;
  assign accept          = in_stream.valid && in_stream.ready;
  assign push            = accept && emit;

  always_comb begin
    if (tab_size == '0) begin
      ts_eff = TAB_W'(1);
    end else if (tab_size > TAB_W'(MAX_TAB)) begin
      ts_eff = TAB_W'(MAX_TAB);
    end else begin
      ts_eff = tab_size;
    end
    // A smaller tab size written since the last block restarts the column.
    col_base = (TAB_W'(block_column) >= ts_eff) ? '0 : TAB_W'(block_column);
    col      = col_base + TAB_W'(1);
    blk_end  = (col >= ts_eff);
    is_space = (in_stream.in_char == CH_SPACE);
    pend_inc = pending_spaces + PEND_W'(1);

    emit            = 1'b1;
    push_cmd.spaces = pending_spaces[COL_W-1:0];
    push_cmd.ch     = in_stream.in_char;
    push_cmd.last   = in_stream.in_last;
    if (is_space) begin
      if (blk_end) begin
        push_cmd.spaces = '0;
        push_cmd.ch     = (pend_inc > PEND_W'(1)) ? CH_TAB : CH_SPACE;
      end else if (in_stream.in_last) begin
        // Flush all held spaces; the last of them closes the command.
        push_cmd.ch = CH_SPACE;
      end else begin
        emit = 1'b0;
      end
    end

    if (blk_end || in_stream.in_last) begin
      block_column_next   = '0;
      pending_spaces_next = '0;
    end else begin
      block_column_next   = col[COL_W-1:0];
      pending_spaces_next = is_space ? pend_inc : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_size       <= TAB_RESET;
      block_column   <= '0;
      pending_spaces <= '0;
    end else begin
      if (cfg_we) begin
        tab_size <= cfg_data;
      end
      if (accept) begin
        block_column   <= block_column_next;
        pending_spaces <= pending_spaces_next;
      end
    end
  end

endmodule

// File: hw/rtl/ste_queue.sv
// Short command queue between the front and back ends, built from flops.
// Depends on ste_pkg and the assertion macro header.
`include "space_to_tab_entab_defines.svh"

module ste_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ste_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output ste_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import ste_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

  `STE_ASSERT(a_count_bound, count <= QUEUE_CW'(QUEUE_DEPTH))
  `STE_ASSERT(a_no_push_full, push |-> !full)
  `STE_ASSERT(a_no_pop_empty, pop |-> !empty)

endmodule

// File: hw/rtl/ste_back.sv
// Back end: expands each queued command into output words, one per cycle while ready.
// Its registers are the output register. Depends on ste_pkg and ste_out_if.
module ste_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_empty,
  input  ste_pkg::cmd_t pop_cmd,
  output logic          pop,
  ste_out_if.source     out_stream
);
  import ste_pkg::*;

  logic             cur_valid;
  logic [COL_W-1:0] cur_spaces;
  logic [7:0]       cur_ch;
  logic             cur_last;
  logic             done;
  logic             out_accept;

  assign done       = (cur_spaces == '0);
  assign out_accept = out_stream.valid && out_stream.ready;
  assign pop        = !queue_empty && (!cur_valid || (out_accept && done));

  assign out_stream.valid    = cur_valid;
  assign out_stream.out_char = done ? cur_ch : CH_SPACE;
  assign out_stream.out_last = done && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid  <= 1'b1;
      cur_spaces <= pop_cmd.spaces;
      cur_ch     <= pop_cmd.ch;
      cur_last   <= pop_cmd.last;
    end else if (out_accept) begin
      if (done) begin
        cur_valid <= 1'b0;
      end else begin
        cur_spaces <= cur_spaces - COL_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/space_to_tab_entab.sv
// Top level of the space-to-tab converter: front end, command queue, back end.
// Depends on ste_pkg, ste_in_if, ste_out_if, ste_front, ste_queue and ste_back.
//
//   Channel     Direction  Word
//   in_stream   sink       in_char[7:0], in_last
//   out_stream  source     out_char[7:0], out_last
//   cfg_we/data write      tab_size[4:0]
//
// The back end sends one output word per cycle while out_stream is ready; an
// input word that releases N held spaces sends N+1 words, at most 16.
// Input is taken every cycle while the four-entry command queue has room, so
// bursts of released spaces stall the input only once the queue fills.
// The first result word is written into the command queue, then loaded into
// the back-end output register, before it is valid at the output.
// Reset clears the column, the held spaces and the queue and sets tab_size to 8.
module space_to_tab_entab (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ste_pkg::TAB_W-1:0] cfg_data,
  ste_in_if.sink                    in_stream,
  ste_out_if.source                 out_stream
);
  import ste_pkg::*;

  logic queue_full;
  logic queue_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  ste_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_stream  (in_stream),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  ste_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (queue_empty)
  );

  ste_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop_cmd     (pop_cmd),
    .pop         (pop),
    .out_stream  (out_stream)
  );

endmodule
